// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the shortest seek first scheduler.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/sstf_pkg.sv -----
// ---------------------------------------------------------------------------
// Scheduler package
// Defaults, field widths and the command and status types of the scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int TRACK_BITS_DEF   = 16;

  localparam int FIELD_W  = 16;
  localparam int TOTAL_W  = 21;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic load;
    logic begin_batch;
    logic calc_dist;
    logic pick;
    logic end_batch;
  } sstf_cmd_t;

  typedef struct packed {
    logic last_pick;
    logic store_full;
  } sstf_status_t;

endpackage

// ----- src/sstf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Scheduler controller
// Sequences loading, the distance stage and the pick stage of each batch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_batch_end,
  input  sstf_pkg::sstf_status_t status,
  output sstf_pkg::sstf_cmd_t   cmd,
  output logic                  busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIST = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_batch_end) begin
            cmd.begin_batch = 1'b1;
            state_nxt       = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        cmd.calc_dist = 1'b1;
        state_nxt     = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        if (status.last_pick) begin
          cmd.end_batch = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DIST;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- src/sstf_datapath.sv -----
// ---------------------------------------------------------------------------
// Scheduler datapath
// Request store, served marks, distance registers, minimum tree and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstf_datapath #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sstf_pkg::sstf_cmd_t           cmd,
  output sstf_pkg::sstf_status_t        status,
  input  logic [sstf_pkg::FIELD_W-1:0]  in_track,
  input  logic                          cfg_we,
  input  logic [sstf_pkg::FIELD_W-1:0]  cfg_start_head,
  output logic                          out_valid,
  output logic [sstf_pkg::FIELD_W-1:0]  out_served_track,
  output logic [sstf_pkg::FIELD_W-1:0]  out_move_distance,
  output logic [sstf_pkg::TOTAL_W-1:0]  out_running_total,
  output logic                          out_final_result,
  output logic                          out_overflowed
);

  localparam int IDX_W  = $clog2(MAX_REQUESTS);
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int LEAVES = 1 << IDX_W;
  localparam int SUM_W  = ((TRACK_BITS > sstf_pkg::TOTAL_W) ? TRACK_BITS
                                                              : sstf_pkg::TOTAL_W) + 1;

  logic [TRACK_BITS-1:0]       store_r [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0]     served_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            pick_cnt_r;
  logic                        drop_r;
  logic [sstf_pkg::FIELD_W-1:0] start_head_r;
  logic [TRACK_BITS-1:0]       head_r;
  logic [sstf_pkg::TOTAL_W-1:0] total_r;
  logic [sstf_pkg::TOTAL_W-1:0] total_nxt;

  logic                        dist_inv_r [LEAVES];
  logic [TRACK_BITS-1:0]       dist_r     [LEAVES];
  logic                        leaf_inv   [LEAVES];
  logic [TRACK_BITS-1:0]       leaf_dist  [LEAVES];

  logic                        node_inv  [2*LEAVES];
  logic [TRACK_BITS-1:0]       node_dist [2*LEAVES];
  logic [IDX_W-1:0]            node_idx  [2*LEAVES];

  logic [IDX_W-1:0]            win_idx;
  logic [TRACK_BITS-1:0]       win_dist;
  logic [TRACK_BITS-1:0]       win_track;
  logic [SUM_W-1:0]            sum;

  logic                        out_valid_r;
  logic [sstf_pkg::FIELD_W-1:0] out_track_r;
  logic [sstf_pkg::FIELD_W-1:0] out_dist_r;
  logic [sstf_pkg::TOTAL_W-1:0] out_total_r;
  logic                        out_final_r;
  logic                        out_ovf_r;

  function automatic logic [TRACK_BITS-1:0] abs_diff(input logic [TRACK_BITS-1:0] a,
                                                     input logic [TRACK_BITS-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign status.store_full = (count_r == CNT_W'(MAX_REQUESTS));
  assign status.last_pick  = ((pick_cnt_r + CNT_W'(1)) == count_r);

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < MAX_REQUESTS) begin : g_real
      assign leaf_inv[i]  = served_r[i] | (CNT_W'(i) >= count_r);
      assign leaf_dist[i] = abs_diff(store_r[i], head_r);
    end else begin : g_pad
      assign leaf_inv[i]  = 1'b1;
      assign leaf_dist[i] = '0;
    end
  end

  // Ties keep the left child, so the lowest load index wins.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_inv[LEAVES+i]  = dist_inv_r[i];
      node_dist[LEAVES+i] = dist_r[i];
      node_idx[LEAVES+i]  = IDX_W'(i);
    end
    node_inv[0]  = 1'b1;
    node_dist[0] = '0;
    node_idx[0]  = '0;
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if ({node_inv[2*n+1], node_dist[2*n+1]} < {node_inv[2*n], node_dist[2*n]}) begin
        node_inv[n]  = node_inv[2*n+1];
        node_dist[n] = node_dist[2*n+1];
        node_idx[n]  = node_idx[2*n+1];
      end else begin
        node_inv[n]  = node_inv[2*n];
        node_dist[n] = node_dist[2*n];
        node_idx[n]  = node_idx[2*n];
      end
    end
  end

  assign win_idx   = node_idx[1];
  assign win_dist  = node_dist[1];
  assign win_track = store_r[win_idx];
  assign sum       = SUM_W'(total_r) + SUM_W'(win_dist);
  assign total_nxt = (sum > SUM_W'(sstf_pkg::TOTAL_MAX)) ? sstf_pkg::TOTAL_MAX
                                                         : sstf_pkg::TOTAL_W'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r     <= '0;
      count_r      <= '0;
      pick_cnt_r   <= '0;
      drop_r       <= 1'b0;
      start_head_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.pick;
      if (cfg_we) begin
        start_head_r <= cfg_start_head;
      end
      if (cmd.load) begin
        if (status.store_full) begin
          drop_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.begin_batch) begin
        served_r   <= '0;
        pick_cnt_r <= '0;
      end
      if (cmd.pick) begin
        served_r[win_idx] <= 1'b1;
        pick_cnt_r        <= pick_cnt_r + CNT_W'(1);
      end
      if (cmd.end_batch) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !status.store_full) begin
      store_r[count_r[IDX_W-1:0]] <= TRACK_BITS'(in_track);
    end
    if (cmd.begin_batch) begin
      head_r  <= TRACK_BITS'(start_head_r);
      total_r <= '0;
    end
    if (cmd.calc_dist) begin
      for (int i = 0; i < LEAVES; i++) begin
        dist_inv_r[i] <= leaf_inv[i];
        dist_r[i]     <= leaf_dist[i];
      end
    end
    if (cmd.pick) begin
      head_r      <= win_track;
      total_r     <= total_nxt;
      out_track_r <= sstf_pkg::FIELD_W'(win_track);
      out_dist_r  <= sstf_pkg::FIELD_W'(win_dist);
      out_total_r <= total_nxt;
      out_final_r <= status.last_pick;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_served_track  = out_track_r;
  assign out_move_distance = out_dist_r;
  assign out_running_total = out_total_r;
  assign out_final_result  = out_final_r;
  assign out_overflowed    = out_ovf_r;

endmodule

// ----- src/shortest_seek_first_scheduler.sv -----
// ---------------------------------------------------------------------------
// Shortest seek first scheduler
// Loads a batch of track requests and emits their shortest seek first order.
// ---------------------------------------------------------------------------
// A request is taken whenever start is high and busy is low. The request
// marked batch_end closes the batch and raises busy until all N stored
// requests have been picked: each pick first registers the distances of all
// requests to the head and then resolves the minimum tree. Results appear one
// per pick, each on out_valid for exactly one cycle, and cannot be held off;
// the final one shows in the first cycle after busy falls, when a new request
// may already be taken. The start head is written through the cfg channel,
// which is always ready, and is sampled when a batch closes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shortest_seek_first_scheduler #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sstf_pkg::FIELD_W-1:0]  in_track,
  input  logic                          in_batch_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sstf_pkg::FIELD_W-1:0]  cfg_start_head,
  output logic                          out_valid,
  output logic [sstf_pkg::FIELD_W-1:0]  out_served_track,
  output logic [sstf_pkg::FIELD_W-1:0]  out_move_distance,
  output logic [sstf_pkg::TOTAL_W-1:0]  out_running_total,
  output logic                          out_final_result,
  output logic                          out_overflowed
);

  sstf_pkg::sstf_cmd_t    cmd;
  sstf_pkg::sstf_status_t status;

  assign cfg_ready = 1'b1;

  sstf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_batch_end (in_batch_end),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  sstf_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_track          (in_track),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_start_head    (cfg_start_head),
    .out_valid         (out_valid),
    .out_served_track  (out_served_track),
    .out_move_distance (out_move_distance),
    .out_running_total (out_running_total),
    .out_final_result  (out_final_result),
    .out_overflowed    (out_overflowed)
  );

  `ASSERT_NEXT(a_close_sets_busy, clk, rst_n, start && !busy && in_batch_end, busy)
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `ASSERT_SAME(a_mid_result_busy, clk, rst_n, out_valid && !out_final_result, busy)
  `ASSERT_SAME(a_final_result_idle, clk, rst_n, out_valid && out_final_result, !busy)

endmodule
